/* rtl/core/swm_pkg.sv */
// Shared constants and types for the sliding window minimum block.
// No dependencies; imported by every module under rtl/core.

package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 11;
  localparam int WINDOW_MAX_DEF = 1024;
  // Cells per group in the two-level output select
  localparam int GROUP          = 32;
  localparam int GROUP_W        = $clog2(GROUP);

  typedef logic signed [DATA_W-1:0] sample_t;

endpackage

/* rtl/core/swm_cell.sv */
// One cell of the minimum chain: holds the minimum of the last k+1 samples.
// Depends on swm_pkg.

module swm_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::sample_t prev,
  output swm_pkg::sample_t val
);
  import swm_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // New window of k+1 = new sample plus the window of k held by the neighbor
  assign val_nxt = (prev < sample) ? prev : sample;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

/* rtl/core/swm_chain.sv */
// Row of WINDOW_MAX minimum cells; cell k holds min of the newest k+1 samples.
// Depends on swm_pkg and swm_cell.

module swm_chain #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                     clk,
  input  logic                                     shift_en,
  input  swm_pkg::sample_t                         sample,
  output logic [WINDOW_MAX-1:0][swm_pkg::DATA_W-1:0] cells
);
  import swm_pkg::*;

  sample_t vals [WINDOW_MAX];

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    sample_t prev;
    if (k == 0) begin : g_head
      assign prev = sample;
    end else begin : g_body
      assign prev = vals[k-1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .sample   (sample),
      .prev     (prev),
      .val      (vals[k])
    );

    assign cells[k] = vals[k];
  end

endmodule

/* rtl/core/swm_sel.sv */
// Two-stage output select: pick one cell per group, then one group.
// Depends on swm_pkg.

module swm_sel #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int NGRP       = (WINDOW_MAX + swm_pkg::GROUP - 1) / swm_pkg::GROUP,
  parameter int HI_W       = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  logic                                       clk,
  input  logic [WINDOW_MAX-1:0][swm_pkg::DATA_W-1:0] cells,
  input  logic                                       grp_ld,
  input  logic [swm_pkg::GROUP_W+HI_W-1:0]           sel_idx,
  input  logic                                       out_ld,
  output swm_pkg::sample_t                           result
);
  import swm_pkg::*;

  logic [NGRP-1:0][GROUP-1:0][DATA_W-1:0] pad;
  logic [NGRP-1:0][DATA_W-1:0]            cand_r;
  logic [NGRP-1:0][DATA_W-1:0]            cand_nxt;
  logic [HI_W-1:0]                        hi_r;
  sample_t                                result_r;

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar j = 0; j < GROUP; j++) begin : g_ent
      if (g * GROUP + j < WINDOW_MAX) begin : g_real
        assign pad[g][j] = cells[g*GROUP+j];
      end else begin : g_fill
        assign pad[g][j] = '0;
      end
    end
    assign cand_nxt[g] = pad[g][sel_idx[GROUP_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (grp_ld) begin
      cand_r <= cand_nxt;
      hi_r   <= sel_idx[GROUP_W+HI_W-1:GROUP_W];
    end
    if (out_ld) begin
      result_r <= sample_t'(cand_r[hi_r]);
    end
  end

  assign result = result_r;

endmodule

/* rtl/core/sliding_window_minimum.sv */
// Sliding window minimum: top level with handshake control and window bookkeeping.
// Depends on swm_pkg, swm_chain and swm_sel.

// Each accepted sample yields one result: the minimum of the newest
// window_length samples, or of all samples since reset while fewer have
// arrived. A row of WINDOW_MAX cells holds the running minimum for every
// window length, so one sample is taken every cycle. The cells update at the
// transfer edge; the group picks are then registered, and the final pick is
// loaded into the output register, where the result is offered. The input
// stalls only while a result waits at the output with both select stages full.
// A write of 0 to window_length acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX, and a new length applies at once to the samples already held.
// Neither channel accepts a transfer during reset. There is no clearing pass
// after reset.
module sliding_window_minimum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // tdata: [31:0] sample
  input  logic [swm_pkg::DATA_W-1:0]   in_tdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tdata: [31:0] window_min
  output logic [swm_pkg::DATA_W-1:0]   out_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // data: [10:0] window_length
  input  logic [swm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int NGRP  = (WINDOW_MAX + GROUP - 1) / GROUP;
  localparam int HI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SEL_W = GROUP_W + HI_W;

  localparam logic [CMP_W-1:0] WMAX_C = CMP_W'(WINDOW_MAX);
  localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1);

  logic [CFG_W-1:0] len_r;
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] seen_nxt;
  logic             v1_r, v2_r, ov_r;
  logic [SEL_W-1:0] idx_r;
  logic [SEL_W-1:0] idx_nxt;

  logic             in_xfer, ld2, ld3, free1, free2;
  logic [CMP_W-1:0] len_eff, seen_ext, span;

  logic [WINDOW_MAX-1:0][DATA_W-1:0] cells;
  sample_t                           result;

  // Pipeline flow: stage 1 holds the select index, stage 2 the group picks
  assign ld3       = v2_r && (!ov_r || out_tready);
  assign free2     = !v2_r || ld3;
  assign ld2       = v1_r && free2;
  assign free1     = !v1_r || ld2;
  assign in_tready = free1 && rst_n;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  // Saturate the sample count and clamp the window length
  assign seen_ext = CMP_W'(seen_r);
  assign seen_nxt = (seen_ext < WMAX_C) ? seen_r + CNT_W'(1) : seen_r;

  always_comb begin
    len_eff = CMP_W'(len_r);
    if (len_eff == '0) begin
      len_eff = ONE_C;
    end else if (len_eff > WMAX_C) begin
      len_eff = WMAX_C;
    end
    span = (len_eff < CMP_W'(seen_nxt)) ? len_eff : CMP_W'(seen_nxt);
  end

  assign idx_nxt = SEL_W'(span - ONE_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= CFG_W'(1);
      seen_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
      if (in_xfer) begin
        seen_r <= seen_nxt;
      end
      if (in_xfer) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ld3) begin
        v2_r <= 1'b0;
      end
      if (ld3) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r <= idx_nxt;
    end
  end

  swm_chain #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_chain (
    .clk      (clk),
    .shift_en (in_xfer),
    .sample   (sample_t'(in_tdata)),
    .cells    (cells)
  );

  swm_sel #(
    .WINDOW_MAX (WINDOW_MAX),
    .NGRP       (NGRP),
    .HI_W       (HI_W)
  ) u_sel (
    .clk     (clk),
    .cells   (cells),
    .grp_ld  (ld2),
    .sel_idx (idx_r),
    .out_ld  (ld3),
    .result  (result)
  );

  assign out_tdata  = DATA_W'(result);
  assign out_tvalid = ov_r;

endmodule

/* tb/sliding_window_minimum_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_minimum: streams signed samples with random
// stalls on both sides and checks every result against a windowed-minimum predictor.
// Depends on swm_pkg and the sliding_window_minimum RTL.

module sliding_window_minimum_tb;
  import swm_pkg::*;

  localparam int WIN_MAX       = WINDOW_MAX_DEF;
  localparam int IDLE_PCT      = 31;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 40;
  localparam int WANT_DEPTH    = 4096;

  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;
  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;

  localparam logic [CFG_W-1:0] LEN_ZERO = '0;
  localparam logic [CFG_W-1:0] LEN_ONE  = CFG_W'(1);
  localparam logic [CFG_W-1:0] LEN_FULL = CFG_W'(WIN_MAX);
  localparam logic [CFG_W-1:0] LEN_OVER = '1;

  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_RAMP_UP,
    PAT_RAMP_DOWN,
    PAT_EXTREME
  } pattern_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic [DATA_W-1:0] in_tdata  = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;

  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic rx_hold   = 1'b0;
  event hold_go;

  // predictor state: circular history of the last WIN_MAX samples,
  // and a ring of results still owed by the block
  sample_t          hist_buf [WIN_MAX];
  int               hist_wr = 0;
  int               hist_cnt = 0;
  logic [CFG_W-1:0] window_cfg = LEN_ONE;
  sample_t          want_buf [WANT_DEPTH];
  int               want_wr = 0;
  int               want_rd = 0;
  sample_t          ramp_value = '0;
  int               mismatch_count = 0;

  sliding_window_minimum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void want_put(input sample_t v);
    want_buf[want_wr % WANT_DEPTH] = v;
    want_wr++;
  endfunction

  function automatic sample_t want_get();
    sample_t v;
    v = want_buf[want_rd % WANT_DEPTH];
    want_rd++;
    return v;
  endfunction

  function automatic int want_count();
    return want_wr - want_rd;
  endfunction

  function automatic sample_t predict_window_min(input sample_t s);
    int      span;
    int      pos;
    sample_t best;
    hist_buf[hist_wr] = s;
    hist_wr = (hist_wr + 1) % WIN_MAX;
    if (hist_cnt < WIN_MAX) hist_cnt++;
    if (window_cfg == LEN_ZERO) span = 1;
    else if (int'(window_cfg) > WIN_MAX) span = WIN_MAX;
    else span = int'(window_cfg);
    // fewer samples than the window: take all of them
    if (span > hist_cnt) span = hist_cnt;
    best = s;
    for (int k = 0; k < span; k++) begin
      pos = (hist_wr + WIN_MAX - 1 - k) % WIN_MAX;
      if (hist_buf[pos] < best) best = hist_buf[pos];
    end
    return best;
  endfunction

  function automatic sample_t next_sample(input pattern_e pat);
    sample_t v;
    // keep some full-range values in every pattern so all bits toggle
    if ($urandom_range(9) == 0) return sample_t'($urandom());
    case (pat)
      PAT_NARROW: begin
        v = sample_t'($urandom_range(8)) - 4;
      end
      PAT_RAMP_UP: begin
        ramp_value = ramp_value + sample_t'($urandom_range(1000));
        v = ramp_value;
      end
      PAT_RAMP_DOWN: begin
        ramp_value = ramp_value - sample_t'($urandom_range(1000));
        v = ramp_value;
      end
      PAT_EXTREME: begin
        case ($urandom_range(5))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          2: v = SAMPLE_MIN + 1;
          3: v = SAMPLE_MAX - 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: begin
        v = sample_t'($urandom());
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && (rx_steady || $urandom_range(99) >= IDLE_PCT);
      if (out_tvalid && out_tready) begin
        if (want_count() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", $signed(out_tdata)));
        end else begin
          want = want_get();
          if (out_tdata !== want) begin
            report_mismatch($sformatf("window_min got %0d want %0d", $signed(out_tdata), want));
          end
        end
      end
    end
  end

  // hold the receiver off for a fixed stretch on request
  initial begin : rx_holdoff
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic send_sample(input sample_t s);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    want_put(predict_window_min(s));
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (want_count() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    wait_drained();
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    window_cfg = len;
  endtask

  task automatic test_directed_cases();
    sample_t corner_vals[7] = '{SAMPLE_MIN, SAMPLE_MAX, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA};
    // reset length of one: each result is the newest sample
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    write_window(CFG_W'(3));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(5);
    send_sample(6);
    send_sample(7);
    // zero length behaves as one
    write_window(LEN_ZERO);
    send_sample(10);
    send_sample(-10);
    send_sample(3);
    // over-range length saturates, and exceeds the samples held so far
    write_window(LEN_OVER);
    send_sample(-5);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] len;
    pattern_e         pat;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: len = LEN_ONE;
        1: len = CFG_W'(2);
        5: len = LEN_OVER;
        8: len = CFG_W'($urandom_range(LEN_OVER));
        9: len = LEN_ZERO;
        default: len = CFG_W'($urandom_range(16, 1));
      endcase
      write_window(len);
      pat = pattern_e'($urandom_range(PAT_EXTREME));
      repeat (100) send_sample(next_sample(pat));
    end
  endtask

  task automatic test_full_window();
    write_window(LEN_FULL);
    // rising ramp keeps the oldest sample as minimum until it leaves the window
    tx_steady <= 1'b1;
    rx_steady <= 1'b1;
    repeat (300) send_sample(next_sample(PAT_RAMP_UP));
    tx_steady <= 1'b0;
    rx_steady <= 1'b0;
    repeat (200) send_sample(next_sample(pattern_e'($urandom_range(PAT_EXTREME))));
  endtask

  task automatic test_output_backpressure();
    write_window(CFG_W'($urandom_range(64, 1)));
    tx_steady <= 1'b1;
    -> hold_go;
    repeat (80) send_sample(next_sample(PAT_RANDOM));
    tx_steady <= 1'b0;
  endtask

  task automatic test_drain_pause();
    write_window(CFG_W'($urandom_range(32, 1)));
    repeat (80) send_sample(next_sample(PAT_RAMP_DOWN));
    wait_drained();
    repeat ($urandom_range(20, 1)) @(posedge clk);
    repeat (80) send_sample(next_sample(PAT_NARROW));
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_windows();
    test_full_window();
    test_output_backpressure();
    test_drain_pause();
    wait_drained();
    while (want_count() != 0) begin
      report_mismatch($sformatf("no result for expected %0d", want_get()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
